/* src/width_masked_int_divider_macros.svh */
// assertion macros for the width-masked integer divider
// used by the top level; no other dependencies
`ifndef WIDTH_MASKED_INT_DIVIDER_MACROS_SVH
`define WIDTH_MASKED_INT_DIVIDER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define WMD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked a fixed number of cycles later
`define WMD_ASSERT_AFTER(lbl, clk, rst_n, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ## (dly) (cons)) \
        else $error(msg);

`endif

/* src/wmd_pkg.sv */
// shared types, constants and helpers of the width-masked integer divider
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wmd_pkg;

    // datapath width and width of the type-width field
    localparam int unsigned DW      = 64;
    localparam int unsigned WW      = 7;
    // start to result strobe: prep stage, one stage per quotient bit, post stage
    localparam int unsigned LATENCY = DW + 2;

    typedef logic [DW-1:0] t_word;

    typedef enum logic {
        REQ_DIV = 1'b0,
        REQ_REM = 1'b1
    } t_req;

    // control that travels alongside the operands
    typedef struct packed {
        logic          rem;
        logic          neg;
        logic          trap;
        logic [WW-1:0] width;
    } t_wmd_ctl;

    // ones in the low w bits, all ones for w of DW or more
    function automatic t_word low_mask(input logic [WW-1:0] w);
        t_word m;
        if (w >= WW'(DW)) begin
            m = '1;
        end else begin
            m = (t_word'(1) << w) - t_word'(1);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* src/wmd_prep.sv */
// input stage: width normalize, operand masking or magnitude, trap detection
// depends on wmd_pkg
`timescale 1ns / 1ps
`default_nettype none

module wmd_prep (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_req_type,
    input  logic               i_is_signed,
    input  logic [6:0]         i_type_width,
    input  wmd_pkg::t_word     i_dividend,
    input  wmd_pkg::t_word     i_divisor,
    output logic               o_valid,
    output wmd_pkg::t_word     o_num,
    output wmd_pkg::t_word     o_den,
    output wmd_pkg::t_wmd_ctl  o_ctl
);
    import wmd_pkg::*;

    logic          r_valid;
    t_word         r_num;
    t_word         n_num;
    t_word         r_den;
    t_word         n_den;
    t_wmd_ctl      r_ctl;
    t_wmd_ctl      n_ctl;
    logic [WW-1:0] w_norm;
    t_word         mask;
    logic          na;
    logic          nb;

    // operand preparation and trap decision
    always_comb begin
        if (i_type_width == '0 || i_type_width >= WW'(DW)) begin
            w_norm = WW'(DW);
        end else begin
            w_norm = i_type_width;
        end
        mask = low_mask(w_norm);
        na   = i_dividend[DW-1];
        nb   = i_divisor[DW-1];
        n_ctl.rem   = (t_req'(i_req_type) == REQ_REM);
        n_ctl.width = w_norm;
        if (i_is_signed) begin
            n_num      = na ? (t_word'(0) - i_dividend) : i_dividend;
            n_den      = nb ? (t_word'(0) - i_divisor) : i_divisor;
            n_ctl.trap = (i_divisor == '0) ||
                         ((i_dividend == ~(mask >> 1)) && (i_divisor == '1));
            n_ctl.neg  = n_ctl.rem ? na : (na ^ nb);
        end else begin
            n_num      = i_dividend & mask;
            n_den      = i_divisor & mask;
            n_ctl.trap = ((i_divisor & mask) == '0);
            n_ctl.neg  = 1'b0;
        end
    end

    // valid with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_den <= n_den;
        r_ctl <= n_ctl;
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_ctl   = r_ctl;

endmodule

`default_nettype wire

/* src/wmd_step.sv */
// one restoring division step: one quotient bit per stage
// depends on wmd_pkg
`timescale 1ns / 1ps
`default_nettype none

module wmd_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  wmd_pkg::t_word     i_part,
    input  wmd_pkg::t_word     i_quo,
    input  wmd_pkg::t_word     i_den,
    input  wmd_pkg::t_wmd_ctl  i_ctl,
    output logic               o_valid,
    output wmd_pkg::t_word     o_part,
    output wmd_pkg::t_word     o_quo,
    output wmd_pkg::t_word     o_den,
    output wmd_pkg::t_wmd_ctl  o_ctl
);
    import wmd_pkg::*;

    logic          r_valid;
    t_word         r_part;
    t_word         n_part;
    t_word         r_quo;
    t_word         n_quo;
    t_word         r_den;
    t_wmd_ctl      r_ctl;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          ge;

    // shift in next dividend bit, trial subtract
    always_comb begin
        shifted = {i_part, i_quo[DW-1]};
        diff    = shifted - {1'b0, i_den};
        ge      = ~diff[DW];
        n_part  = ge ? diff[DW-1:0] : shifted[DW-1:0];
        n_quo   = {i_quo[DW-2:0], ge};
    end

    // valid with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_part <= n_part;
        r_quo  <= n_quo;
        r_den  <= i_den;
        r_ctl  <= i_ctl;
    end

    assign o_valid = r_valid;
    assign o_part  = r_part;
    assign o_quo   = r_quo;
    assign o_den   = r_den;
    assign o_ctl   = r_ctl;

endmodule

`default_nettype wire

/* src/wmd_post.sv */
// output stage: select, sign fix, wrap to the type width, trap zeroing
// depends on wmd_pkg
`timescale 1ns / 1ps
`default_nettype none

module wmd_post (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  wmd_pkg::t_word     i_part,
    input  wmd_pkg::t_word     i_quo,
    input  wmd_pkg::t_wmd_ctl  i_ctl,
    output logic               o_valid,
    output wmd_pkg::t_word     o_value,
    output logic               o_trap
);
    import wmd_pkg::*;

    localparam int unsigned IW = $clog2(DW);

    logic          r_valid;
    t_word         r_value;
    t_word         n_value;
    logic          r_trap;
    t_word         sel;
    t_word         sgn;
    t_word         mask;
    logic [IW-1:0] top_idx;
    logic          top_bit;

    // quotient or remainder, signed, wrapped and sign-extended
    always_comb begin
        sel     = i_ctl.rem ? i_part : i_quo;
        sgn     = i_ctl.neg ? (t_word'(0) - sel) : sel;
        mask    = low_mask(i_ctl.width);
        top_idx = IW'(i_ctl.width - WW'(1));
        top_bit = sgn[top_idx];
        if (i_ctl.trap) begin
            n_value = '0;
        end else if (top_bit) begin
            n_value = sgn | ~mask;
        end else begin
            n_value = sgn & mask;
        end
    end

    // valid with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_trap  <= i_ctl.trap;
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_trap  = r_trap;

endmodule

`default_nettype wire

/* src/width_masked_int_divider.sv */
// Width-masked signed/unsigned 64-bit integer divider with trap.
//
// Request channel: drive the operands, type width, signedness and divide or
// remainder select together with start; a transaction is taken at each rising
// edge where start is high and busy is low. busy is only high during reset,
// so a new request can be issued every cycle.
// Result channel: o_done is high for exactly one cycle with o_result_value and
// o_trap; the receiver must take it then, there is no way to hold it off.
// Pipeline: an accepted request passes one input stage, 64 one-bit division
// stages and one output stage before o_done is raised.
// Throughput: one transaction per cycle outside reset, results in order.
// A trapped transaction (zero divisor, signed width minimum by -1) returns 0.
// Reset: synchronous, active low; all transactions in flight are dropped and
// no strobe follows for them.
`timescale 1ns / 1ps
`default_nettype none
`include "width_masked_int_divider_macros.svh"

module width_masked_int_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_req_type,
    input  logic               i_is_signed,
    input  logic [6:0]         i_type_width,
    input  wmd_pkg::t_word     i_dividend,
    input  wmd_pkg::t_word     i_divisor,
    output logic               o_done,
    output wmd_pkg::t_word     o_result_value,
    output logic               o_trap
);
    import wmd_pkg::*;

    logic      accept;
    logic      st_valid [0:DW];
    t_word     st_part  [0:DW];
    t_word     st_quo   [0:DW];
    t_word     st_den   [0:DW];
    t_wmd_ctl  st_ctl   [0:DW];

    // request handshake
    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    // input stage
    wmd_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (accept),
        .i_req_type   (i_req_type),
        .i_is_signed  (i_is_signed),
        .i_type_width (i_type_width),
        .i_dividend   (i_dividend),
        .i_divisor    (i_divisor),
        .o_valid      (st_valid[0]),
        .o_num        (st_quo[0]),
        .o_den        (st_den[0]),
        .o_ctl        (st_ctl[0])
    );

    assign st_part[0] = '0;

    // one stage per quotient bit
    for (genvar g = 0; g < DW; g++) begin : g_step
        wmd_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_valid[g]),
            .i_part  (st_part[g]),
            .i_quo   (st_quo[g]),
            .i_den   (st_den[g]),
            .i_ctl   (st_ctl[g]),
            .o_valid (st_valid[g+1]),
            .o_part  (st_part[g+1]),
            .o_quo   (st_quo[g+1]),
            .o_den   (st_den[g+1]),
            .o_ctl   (st_ctl[g+1])
        );
    end

    // output stage
    wmd_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (st_valid[DW]),
        .i_part  (st_part[DW]),
        .i_quo   (st_quo[DW]),
        .i_ctl   (st_ctl[DW]),
        .o_valid (o_done),
        .o_value (o_result_value),
        .o_trap  (o_trap)
    );

    // every accepted transaction gets its strobe after the fixed latency
    `WMD_ASSERT_AFTER(a_latency, i_clk, i_rst_n, accept, LATENCY, o_done, "missing result strobe")
    // an unsigned zero divisor must trap
    `WMD_ASSERT_AFTER(a_zero_div_trap, i_clk, i_rst_n, accept && !i_is_signed && i_divisor == '0, LATENCY, o_done && o_trap, "zero divisor did not trap")
    // a trapped result reads as zero
    `WMD_ASSERT_NOW(a_trap_zero, i_clk, i_rst_n, o_done && o_trap, o_result_value == '0, "trap with nonzero result")

endmodule

`default_nettype wire

/* test/quotient_checker.sv */
// checker for the width-masked integer divider: predicts each request and
// compares the result strobes in order; depends on wmd_pkg only
`timescale 1ns / 1ps

module quotient_checker (
    input  logic               i_clk,
    input  logic               i_start,
    input  logic               i_busy,
    input  wmd_pkg::t_req      i_req_type,
    input  logic               i_is_signed,
    input  logic [6:0]         i_type_width,
    input  wmd_pkg::t_word     i_dividend,
    input  wmd_pkg::t_word     i_divisor,
    input  logic               i_done,
    input  wmd_pkg::t_word     i_result_value,
    input  logic               i_trap,
    output int                 o_fail_count,
    output int                 o_pending
);
    import wmd_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // one request with its predicted outcome
    typedef struct {
        t_req          op;
        logic          sgn;
        logic [WW-1:0] tw;
        t_word         a;
        t_word         b;
        t_word         value;
        logic          trap;
    } t_division;

    t_division awaited_divisions[$];
    int        mismatches = 0;

    // keep the low w bits and sign-extend from bit w-1
    function automatic t_word sign_wrap(input t_word v, input int unsigned w);
        t_word m;
        if (w < DW) begin
            m = (t_word'(1) << w) - t_word'(1);
            v = v & m;
            if (v[w-1]) begin
                v = v | ~m;
            end
        end
        return v;
    endfunction

    // expected quotient or remainder and trap for one request
    function automatic t_division divide_masked(input t_req op, input logic sgn,
                                                input logic [WW-1:0] tw,
                                                input t_word a, input t_word b);
        t_division   d;
        int unsigned w;
        t_word       m;
        t_word       minv;
        t_word       ma;
        t_word       mb;
        t_word       r;
        logic        neg;
        d.op    = op;
        d.sgn   = sgn;
        d.tw    = tw;
        d.a     = a;
        d.b     = b;
        d.value = '0;
        w = (tw == 0 || tw >= DW) ? DW : int'(tw);
        m = (w >= DW) ? {DW{1'b1}} : (t_word'(1) << w) - t_word'(1);
        if (!sgn) begin
            // unsigned: both operands masked, zero test on the masked divisor
            ma     = a & m;
            mb     = b & m;
            d.trap = (mb == '0);
            if (!d.trap) begin
                d.value = sign_wrap((op == REQ_REM) ? ma % mb : ma / mb, w);
            end
        end else begin
            // signed: full-width operands, trap on zero or width minimum by -1
            minv = (w >= DW) ? (t_word'(1) << (DW - 1))
                             : ~((t_word'(1) << (w - 1)) - t_word'(1));
            d.trap = (b == '0) || (a == minv && b == {DW{1'b1}});
            if (!d.trap) begin
                ma = a[DW-1] ? t_word'(0) - a : a;
                mb = b[DW-1] ? t_word'(0) - b : b;
                if (op == REQ_REM) begin
                    r   = ma % mb;
                    neg = a[DW-1];
                end else begin
                    r   = ma / mb;
                    neg = a[DW-1] ^ b[DW-1];
                end
                if (neg) begin
                    r = t_word'(0) - r;
                end
                d.value = sign_wrap(r, w);
            end
        end
        return d;
    endfunction

    // compare result strobes first, then record the new transaction
    always @(posedge i_clk) begin
        t_division exp_d;
        int        fails;
        fails = o_fail_count;
        if (i_done) begin
            if (awaited_divisions.size() == 0) begin
                fails++;
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected result: value=%h trap=%0b", i_result_value, i_trap);
                end
            end else begin
                exp_d = awaited_divisions.pop_front();
                if (i_result_value !== exp_d.value || i_trap !== exp_d.trap) begin
                    fails++;
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("mismatch: op=%0d signed=%0b width=%0d a=%h b=%h",
                                 exp_d.op, exp_d.sgn, exp_d.tw, exp_d.a, exp_d.b);
                        $display("  expected value=%h trap=%0b, got value=%h trap=%0b",
                                 exp_d.value, exp_d.trap, i_result_value, i_trap);
                    end
                end
            end
        end
        if (i_start && !i_busy) begin
            awaited_divisions.push_back(divide_masked(i_req_type, i_is_signed,
                                                      i_type_width, i_dividend, i_divisor));
        end
        o_fail_count <= fails;
        o_pending    <= awaited_divisions.size();
    end

endmodule

/* test/testbench.sv */
// top of the width-masked integer divider testbench: clock, reset, directed
// and random requests, verdict; depends on wmd_pkg, the divider and quotient_checker
`timescale 1ns / 1ps

module testbench;
    import wmd_pkg::*;

    localparam int    IDLE_LIMIT = 20 * LATENCY;
    localparam int    GROUPS     = 23;
    localparam int    GROUP_SIZE = 50;
    localparam t_word WORD_MIN   = t_word'(1) << (DW - 1);
    localparam t_word WORD_MAX   = ~WORD_MIN;
    localparam t_word ALL_ONES   = {DW{1'b1}};

    logic          i_clk        = 1'b0;
    logic          i_rst_n      = 1'b0;
    logic          start        = 1'b0;
    logic          busy;
    t_req          i_req_type   = REQ_DIV;
    logic          i_is_signed  = 1'b0;
    logic [WW-1:0] i_type_width = '0;
    t_word         i_dividend   = '0;
    t_word         i_divisor    = '0;
    logic          o_done;
    t_word         o_result_value;
    logic          o_trap;
    int            fail_count;
    int            pending_results;
    int            idle_cycles  = 0;

    // 8 ns clock
    always #4 i_clk = ~i_clk;

    width_masked_int_divider dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_is_signed    (i_is_signed),
        .i_type_width   (i_type_width),
        .i_dividend     (i_dividend),
        .i_divisor      (i_divisor),
        .o_done         (o_done),
        .o_result_value (o_result_value),
        .o_trap         (o_trap)
    );

    quotient_checker div_check (
        .i_clk          (i_clk),
        .i_start        (start),
        .i_busy         (busy),
        .i_req_type     (i_req_type),
        .i_is_signed    (i_is_signed),
        .i_type_width   (i_type_width),
        .i_dividend     (i_dividend),
        .i_divisor      (i_divisor),
        .i_done         (o_done),
        .i_result_value (o_result_value),
        .i_trap         (o_trap),
        .o_fail_count   (fail_count),
        .o_pending      (pending_results)
    );

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // wait gap cycles with start low, then hold the request until taken
    task automatic issue_division(input t_req op, input logic sgn, input logic [WW-1:0] tw,
                                  input t_word a, input t_word b, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_req_type   <= op;
        i_is_signed  <= sgn;
        i_type_width <= tw;
        i_dividend   <= a;
        i_divisor    <= b;
        do @(posedge i_clk); while (busy);
    endtask

    // stop sending until every outstanding result has come back
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
    endtask

    // type widths: full, oversized, common and arbitrary
    function automatic logic [WW-1:0] pick_width();
        logic [WW-1:0] tw;
        case ($urandom_range(0, 7))
            0:       tw = '0;
            1:       tw = WW'(DW);
            2:       tw = WW'($urandom_range(65, 127));
            3:       tw = WW'(8 << $urandom_range(0, 2));
            default: tw = WW'($urandom_range(1, 63));
        endcase
        return tw;
    endfunction

    // operands shaped around the effective width w
    function automatic t_word pick_operand(input int unsigned w);
        t_word v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = {$urandom, $urandom};
            3, 4: begin
                v = t_word'($urandom_range(0, 15));
                if ($urandom_range(0, 1)) begin
                    v = t_word'(0) - v;
                end
            end
            5, 6: begin
                v = {$urandom, $urandom};
                v = $signed(v << (DW - w)) >>> (DW - w);
            end
            7: begin
                case ($urandom_range(0, 5))
                    0:       v = ~((t_word'(1) << (w - 1)) - t_word'(1));
                    1:       v = (t_word'(1) << (w - 1)) - t_word'(1);
                    2:       v = ALL_ONES;
                    3:       v = '0;
                    4:       v = t_word'(1);
                    default: v = WORD_MIN;
                endcase
            end
            8:       v = (w < DW) ? ({$urandom, $urandom} << w) : '0;
            default: v = ALL_ONES;
        endcase
        return v;
    endfunction

    initial begin
        t_req          op;
        logic          sgn;
        logic [WW-1:0] tw;
        int unsigned   ew;
        logic          quiet;
        t_word         a;
        t_word         b;

        // reset
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, both operations and the listed corner cases
        issue_division(REQ_DIV, 1'b0, 7'd0, WORD_MAX, 64'd3, $urandom_range(0, 7));
        issue_division(REQ_REM, 1'b0, 7'd64, ALL_ONES, 64'd7, $urandom_range(0, 7));
        // full-width minimum by -1 traps for width 0 and 64
        issue_division(REQ_DIV, 1'b1, 7'd0, WORD_MIN, ALL_ONES, $urandom_range(0, 7));
        issue_division(REQ_REM, 1'b1, 7'd64, WORD_MIN, ALL_ONES, $urandom_range(0, 7));
        // byte minimum by -1 traps, the unextended pattern does not
        issue_division(REQ_DIV, 1'b1, 7'd8, 64'hFFFF_FFFF_FFFF_FF80, ALL_ONES, 0);
        issue_division(REQ_DIV, 1'b1, 7'd8, 64'h80, ALL_ONES, 0);
        // dividend beyond the width wraps without trap
        issue_division(REQ_DIV, 1'b1, 7'd8, WORD_MIN, ALL_ONES, $urandom_range(0, 7));
        // masked-out divisor traps only when unsigned
        issue_division(REQ_DIV, 1'b0, 7'd8, 64'h1234, 64'h100, 0);
        issue_division(REQ_DIV, 1'b1, 7'd8, 64'h1234, 64'h100, 0);
        // zero divisor
        issue_division(REQ_REM, 1'b1, 7'd0, 64'd99, 64'd0, $urandom_range(0, 7));
        issue_division(REQ_DIV, 1'b0, 7'd0, 64'd99, 64'd0, 0);
        // oversized widths act as full width
        issue_division(REQ_DIV, 1'b1, 7'd100, t_word'(-64'sd7), 64'd2, 0);
        issue_division(REQ_REM, 1'b1, 7'd127, t_word'(-64'sd7), 64'd2, $urandom_range(0, 7));
        issue_division(REQ_REM, 1'b1, 7'd64, 64'd7, t_word'(-64'sd2), 0);
        // one-bit width: -1 is the minimum
        issue_division(REQ_DIV, 1'b1, 7'd1, ALL_ONES, ALL_ONES, 0);
        issue_division(REQ_DIV, 1'b0, 7'd1, 64'd1, 64'd1, $urandom_range(0, 7));
        issue_division(REQ_DIV, 1'b0, 7'd63, ALL_ONES, 64'd1, 0);
        issue_division(REQ_DIV, 1'b1, 7'd32, WORD_MAX, 64'd1, 0);
        issue_division(REQ_REM, 1'b0, 7'd16, 64'hFFFF, 64'hFFFF, $urandom_range(0, 7));
        issue_division(REQ_DIV, 1'b0, 7'd0, 64'd0, ALL_ONES, 0);
        issue_division(REQ_REM, 1'b1, 7'd0, WORD_MAX, WORD_MIN, 0);
        issue_division(REQ_DIV, 1'b1, 7'd0, WORD_MIN, 64'd1, $urandom_range(0, 7));
        issue_division(REQ_DIV, 1'b1, 7'd32, 64'hFFFF_FFFF_8000_0000, ALL_ONES, 0);
        drain_results();

        // random groups, some back to back, some with random gaps
        for (int g = 0; g < GROUPS; g++) begin
            quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < GROUP_SIZE; k++) begin
                op  = $urandom_range(0, 1) ? REQ_REM : REQ_DIV;
                sgn = 1'($urandom_range(0, 1));
                tw  = pick_width();
                ew  = (tw == 0 || tw >= DW) ? DW : int'(tw);
                a   = pick_operand(ew);
                b   = pick_operand(ew);
                issue_division(op, sgn, tw, a, b, quiet ? 0 : $urandom_range(0, 7));
            end
            if ($urandom_range(0, 3) == 0) begin
                drain_results();
            end
        end

        // let everything come back, then a margin for stray strobes
        drain_results();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/wmd_pkg.sv
src/wmd_prep.sv
src/wmd_step.sv
src/wmd_post.sv
src/width_masked_int_divider.sv
test/quotient_checker.sv
test/testbench.sv
